// ----- hw/rtl/clock_calendar_field_editor_defines.svh -----
// assertion macros for the clock calendar field editor
// expects clk and rst_n in the scope of each use
`ifndef CLOCK_CALENDAR_FIELD_EDITOR_DEFINES_SVH
`define CLOCK_CALENDAR_FIELD_EDITOR_DEFINES_SVH

`ifndef ASSERT_OFF
// checked property, off while reset is held
`define CCFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, also during reset
`define CCFE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CCFE_ASSERT(lbl, prop, msg)
`define CCFE_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ----- hw/rtl/ccfe_pkg.sv -----
// types, constants and step functions for the clock calendar field editor
// no dependencies
package ccfe_pkg;

  // request kinds
  localparam logic OP_BUTTON = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // edit modes
  localparam logic [2:0] MODE_RUN     = 3'd0;
  localparam logic [2:0] MODE_HOUR    = 3'd1;
  localparam logic [2:0] MODE_MINUTE  = 3'd2;
  localparam logic [2:0] MODE_SECOND  = 3'd3;
  localparam logic [2:0] MODE_WEEKDAY = 3'd4;
  localparam logic [2:0] MODE_DATE    = 3'd5;
  localparam logic [2:0] MODE_MONTH   = 3'd6;
  localparam logic [2:0] MODE_YEAR    = 3'd7;

  // months with special lengths
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;

  // field limits, 7 bits wide to share one step function
  localparam logic [6:0] HOUR_MAX    = 7'd23;
  localparam logic [6:0] MINUTE_MAX  = 7'd59;
  localparam logic [6:0] SECOND_MAX  = 7'd59;
  localparam logic [6:0] WEEKDAY_MIN = 7'd1;
  localparam logic [6:0] WEEKDAY_MAX = 7'd7;
  localparam logic [6:0] DATE_MIN    = 7'd1;
  localparam logic [6:0] MONTH_MIN   = 7'd1;
  localparam logic [6:0] MONTH_MAX   = 7'd12;
  localparam logic [6:0] YEAR_MAX    = 7'd99;
  localparam logic [6:0] FIELD_ZERO  = 7'd0;
  localparam logic [6:0] LEN_SHORT   = 7'd30;
  localparam logic [6:0] LEN_LONG    = 7'd31;
  localparam logic [6:0] LEN_FEB     = 7'd28;
  localparam logic [6:0] LEN_FEB_LEAP = 7'd29;

  // default date loaded by set plus clear
  localparam logic [2:0] DEF_WEEKDAY = 3'd4;
  localparam logic [4:0] DEF_DATE    = 5'd8;
  localparam logic [3:0] DEF_MONTH   = 4'd6;
  localparam logic [6:0] DEF_YEAR    = 7'h11;

  typedef struct packed {
    logic       op;
    logic       btn_set;
    logic       btn_up;
    logic       btn_down;
    logic       btn_clear;
    logic [5:0] load_second;
    logic [5:0] load_minute;
    logic [4:0] load_hour;
    logic [2:0] load_weekday;
    logic [4:0] load_date;
    logic [3:0] load_month;
    logic [6:0] load_year;
  } ccfe_in_t;

  typedef struct packed {
    logic [2:0] edit_mode;
    logic [4:0] out_hour;
    logic [5:0] out_minute;
    logic [5:0] out_second;
    logic [2:0] out_weekday;
    logic [4:0] out_date;
    logic [3:0] out_month;
    logic [6:0] out_year;
    logic       write_back;
  } ccfe_out_t;

  // up edge first, then down edge; out of range goes to lo on up and to hi on down
  function automatic logic [6:0] field_step(input logic [6:0] v, input logic [6:0] lo,
                                            input logic [6:0] hi, input logic up,
                                            input logic dn);
    logic [6:0] t;
    t = v;
    if (up) begin
      t = (t >= hi || t < lo) ? lo : t + 7'd1;
    end
    if (dn) begin
      t = (t <= lo || t > hi) ? hi : t - 7'd1;
    end
    return t;
  endfunction

  // days in month, leap year taken as year mod 4
  function automatic logic [6:0] month_len(input logic [3:0] month, input logic [6:0] year);
    logic [6:0] len;
    case (month) inside
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
      MONTH_FEB: len = (year[1:0] == 2'b00) ? LEN_FEB_LEAP : LEN_FEB;
      default: len = LEN_LONG;
    endcase
    return len;
  endfunction

endpackage

// ----- hw/rtl/ccfe_core.sv -----
// editor state and next-state logic for one request per cycle while fire is high
// depends on ccfe_pkg
module ccfe_core
  import ccfe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  ccfe_in_t  item,
  output ccfe_out_t result
);

  logic [2:0] mode_r, mode_nxt;
  logic [4:0] hour_r, hour_nxt;
  logic [5:0] minute_r, minute_nxt;
  logic [5:0] second_r, second_nxt;
  logic [2:0] weekday_r, weekday_nxt;
  logic [4:0] date_r, date_nxt;
  logic [3:0] month_r, month_nxt;
  logic [6:0] year_r, year_nxt;
  logic       dirty_r, dirty_nxt;
  logic       set_prev_r, set_prev_nxt;
  logic       up_prev_r, up_prev_nxt;
  logic       down_prev_r, down_prev_nxt;

  logic       wb;
  logic       set_fall;
  logic       up_edge;
  logic       down_edge;
  logic [2:0] mode_tmp;
  logic [6:0] step_val;

  always_comb begin
    mode_nxt      = mode_r;
    hour_nxt      = hour_r;
    minute_nxt    = minute_r;
    second_nxt    = second_r;
    weekday_nxt   = weekday_r;
    date_nxt      = date_r;
    month_nxt     = month_r;
    year_nxt      = year_r;
    dirty_nxt     = dirty_r;
    set_prev_nxt  = set_prev_r;
    up_prev_nxt   = up_prev_r;
    down_prev_nxt = down_prev_r;
    wb            = 1'b0;
    set_fall      = set_prev_r & ~item.btn_set;
    up_edge       = up_prev_r & ~item.btn_up;
    down_edge     = down_prev_r & ~item.btn_down;
    mode_tmp      = mode_r;
    step_val      = FIELD_ZERO;

    if (item.op == OP_LOAD) begin
      if (mode_r == MODE_RUN) begin
        if (dirty_r) begin
          wb        = 1'b1;
          dirty_nxt = 1'b0;
        end else begin
          second_nxt  = item.load_second;
          minute_nxt  = item.load_minute;
          hour_nxt    = item.load_hour;
          weekday_nxt = item.load_weekday;
          date_nxt    = item.load_date;
          month_nxt   = item.load_month;
          year_nxt    = item.load_year;
        end
      end
    end else begin
      if (set_fall) begin
        if (!item.btn_clear) begin
          second_nxt  = 6'd0;
          minute_nxt  = 6'd0;
          hour_nxt    = 5'd0;
          weekday_nxt = DEF_WEEKDAY;
          date_nxt    = DEF_DATE;
          month_nxt   = DEF_MONTH;
          year_nxt    = DEF_YEAR;
          wb          = 1'b1;
        end
        mode_tmp = mode_r + 3'd1;
      end
      set_prev_nxt = item.btn_set;
      if (!item.btn_clear) begin
        mode_tmp = MODE_RUN;
      end
      mode_nxt = mode_tmp;
      // clear forces run mode, so defaults and edits never meet
      if (mode_tmp != MODE_RUN) begin
        up_prev_nxt   = item.btn_up;
        down_prev_nxt = item.btn_down;
        dirty_nxt     = 1'b1;
        unique case (mode_tmp)
          MODE_HOUR: begin
            step_val = field_step({2'b00, hour_r}, FIELD_ZERO, HOUR_MAX, up_edge, down_edge);
            hour_nxt = step_val[4:0];
          end
          MODE_MINUTE: begin
            step_val   = field_step({1'b0, minute_r}, FIELD_ZERO, MINUTE_MAX, up_edge,
                                    down_edge);
            minute_nxt = step_val[5:0];
          end
          MODE_SECOND: begin
            step_val   = field_step({1'b0, second_r}, FIELD_ZERO, SECOND_MAX, up_edge,
                                    down_edge);
            second_nxt = step_val[5:0];
          end
          MODE_WEEKDAY: begin
            step_val    = field_step({4'b0000, weekday_r}, WEEKDAY_MIN, WEEKDAY_MAX, up_edge,
                                     down_edge);
            weekday_nxt = step_val[2:0];
          end
          MODE_DATE: begin
            step_val = field_step({2'b00, date_r}, DATE_MIN, month_len(month_r, year_r),
                                  up_edge, down_edge);
            date_nxt = step_val[4:0];
          end
          MODE_MONTH: begin
            step_val  = field_step({3'b000, month_r}, MONTH_MIN, MONTH_MAX, up_edge,
                                   down_edge);
            month_nxt = step_val[3:0];
          end
          MODE_YEAR: begin
            step_val = field_step(year_r, FIELD_ZERO, YEAR_MAX, up_edge, down_edge);
            year_nxt = step_val;
          end
          default: begin
            step_val = FIELD_ZERO;
          end
        endcase
      end
    end

    result.edit_mode   = mode_nxt;
    result.out_hour    = hour_nxt;
    result.out_minute  = minute_nxt;
    result.out_second  = second_nxt;
    result.out_weekday = weekday_nxt;
    result.out_date    = date_nxt;
    result.out_month   = month_nxt;
    result.out_year    = year_nxt;
    result.write_back  = wb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_RUN;
      hour_r      <= 5'd0;
      minute_r    <= 6'd0;
      second_r    <= 6'd0;
      weekday_r   <= 3'd0;
      date_r      <= 5'd0;
      month_r     <= 4'd0;
      year_r      <= 7'd0;
      dirty_r     <= 1'b0;
      set_prev_r  <= 1'b0;
      up_prev_r   <= 1'b0;
      down_prev_r <= 1'b0;
    end else if (fire) begin
      mode_r      <= mode_nxt;
      hour_r      <= hour_nxt;
      minute_r    <= minute_nxt;
      second_r    <= second_nxt;
      weekday_r   <= weekday_nxt;
      date_r      <= date_nxt;
      month_r     <= month_nxt;
      year_r      <= year_nxt;
      dirty_r     <= dirty_nxt;
      set_prev_r  <= set_prev_nxt;
      up_prev_r   <= up_prev_nxt;
      down_prev_r <= down_prev_nxt;
    end
  end

endmodule

// ----- hw/rtl/clock_calendar_field_editor.sv -----
// clock calendar field editor top level: input register, ccfe_core, result register
// a request accepted into the input register reaches out_data via the result register
// throughput: one request per cycle unless out_ready holds off, set by the core state update
// reset (rst_n low, synchronous) empties both registers and clears all editor state
// depends on ccfe_pkg, ccfe_core and clock_calendar_field_editor_defines.svh
`include "clock_calendar_field_editor_defines.svh"

module clock_calendar_field_editor
  import ccfe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ccfe_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output ccfe_out_t out_data
);

  // input stage holds one request
  ccfe_in_t  in_r;
  logic      in_valid_r;
  // result stage holds one finished result
  ccfe_out_t out_r;
  logic      out_valid_r;

  ccfe_out_t core_result;
  logic      s1_adv;
  logic      in_fire;

  // the input stage moves on whenever the result stage is empty or being drained
  assign s1_adv   = in_valid_r && (!out_valid_r || out_ready);
  // a new request enters while the held one moves on, so full rate is kept
  assign in_ready = !in_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  // state is updated exactly when the held request turns into a result
  ccfe_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_adv),
    .item   (in_r),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_fire) begin
      in_valid_r <= 1'b1;
    end else if (s1_adv) begin
      in_valid_r <= 1'b0;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= core_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a request leaving the input stage always lands in the result stage
  `CCFE_ASSERT(a_adv_to_out, s1_adv |=> out_valid_r, "result lost after input stage advance")
  // a stalled input side means the input stage is occupied
  `CCFE_ASSERT(a_ready_low_full, !in_ready |-> in_valid_r, "in_ready low with empty input stage")
  // write-back is only ever asked for in run mode
  `CCFE_ASSERT(a_wb_run_mode,
               (out_valid_r && out_r.write_back) |-> (out_r.edit_mode == MODE_RUN),
               "write-back outside run mode")
  // reset leaves no result pending
  `CCFE_ASSERT_RST(a_reset_empty, !rst_n |=> (!out_valid_r && !in_valid_r),
                   "pipeline not empty after reset")

endmodule

// ----- test/tb_clock_calendar_field_editor.sv -----
// testbench for clock_calendar_field_editor: directed and random keypad and load requests,
// expected display values predicted in-line and checked against every result
// depends on ccfe_pkg and the clock_calendar_field_editor rtl
`timescale 1ns / 100ps

module tb_clock_calendar_field_editor
  import ccfe_pkg::*;
();

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // dut ports, all driven to known values from time zero
  logic      in_valid = 1'b0;
  logic      in_ready;
  ccfe_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  ccfe_out_t out_data;

  // request source and expected display store
  ccfe_in_t  pending_reqs[$];
  ccfe_out_t expected_display[$];

  // bookkeeping
  int         n_accepted = 0;
  int         n_loads = 0;
  int         n_results = 0;
  int         n_write_backs = 0;
  int         mismatches = 0;
  logic [7:0] modes_seen = '0;
  logic       hold_rx = 1'b0;
  logic       no_idle;

  // predicted editor state, reset values
  logic [2:0] ed_mode = '0;
  logic [4:0] ed_hour = '0;
  logic [5:0] ed_minute = '0;
  logic [5:0] ed_second = '0;
  logic [2:0] ed_weekday = '0;
  logic [4:0] ed_date = '0;
  logic [3:0] ed_month = '0;
  logic [6:0] ed_year = '0;
  logic       ed_dirty = 1'b0;
  logic       prev_set = 1'b0;
  logic       prev_up = 1'b0;
  logic       prev_down = 1'b0;

  clock_calendar_field_editor dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // one stretch of the run where neither side idles
  assign no_idle = (n_accepted >= 400) && (n_accepted < 700);

  // ---------------------------------------------------------------------------
  // display value prediction
  // ---------------------------------------------------------------------------

  // up: at or past the top, or below the bottom, lands on the bottom
  function automatic logic [6:0] wrap_up(input logic [6:0] v, input logic [6:0] lo,
                                         input logic [6:0] hi);
    return (v >= hi || v < lo) ? lo : v + 7'd1;
  endfunction

  // down: at or below the bottom, or above the top, lands on the top
  function automatic logic [6:0] wrap_down(input logic [6:0] v, input logic [6:0] lo,
                                           input logic [6:0] hi);
    return (v <= lo || v > hi) ? hi : v - 7'd1;
  endfunction

  // month length from the current month and year, leap year is year mod 4
  function automatic logic [6:0] days_in_month();
    if (ed_month == MONTH_APR || ed_month == MONTH_JUN || ed_month == MONTH_SEP ||
        ed_month == MONTH_NOV) begin
      return 7'd30;
    end
    if (ed_month == MONTH_FEB) begin
      return (ed_year[1:0] == 2'b00) ? 7'd29 : 7'd28;
    end
    return 7'd31;
  endfunction

  // move the field that the edit mode selects by one step
  function automatic void nudge_field(input logic up);
    case (ed_mode)
      MODE_HOUR: begin
        ed_hour = 5'(up ? wrap_up(7'(ed_hour), 7'd0, 7'd23)
                        : wrap_down(7'(ed_hour), 7'd0, 7'd23));
      end
      MODE_MINUTE: begin
        ed_minute = 6'(up ? wrap_up(7'(ed_minute), 7'd0, 7'd59)
                          : wrap_down(7'(ed_minute), 7'd0, 7'd59));
      end
      MODE_SECOND: begin
        ed_second = 6'(up ? wrap_up(7'(ed_second), 7'd0, 7'd59)
                          : wrap_down(7'(ed_second), 7'd0, 7'd59));
      end
      MODE_WEEKDAY: begin
        ed_weekday = 3'(up ? wrap_up(7'(ed_weekday), 7'd1, 7'd7)
                           : wrap_down(7'(ed_weekday), 7'd1, 7'd7));
      end
      MODE_DATE: begin
        ed_date = 5'(up ? wrap_up(7'(ed_date), 7'd1, days_in_month())
                        : wrap_down(7'(ed_date), 7'd1, days_in_month()));
      end
      MODE_MONTH: begin
        ed_month = 4'(up ? wrap_up(7'(ed_month), 7'd1, 7'd12)
                         : wrap_down(7'(ed_month), 7'd1, 7'd12));
      end
      MODE_YEAR: begin
        ed_year = up ? wrap_up(ed_year, 7'd0, 7'd99) : wrap_down(ed_year, 7'd0, 7'd99);
      end
      default: begin
      end
    endcase
  endfunction

  // apply one request to the predicted state, return the display it should give
  function automatic ccfe_out_t apply_request(input ccfe_in_t r);
    ccfe_out_t o;
    logic      wb;
    logic      up_edge;
    logic      down_edge;
    wb = 1'b0;
    if (r.op == OP_LOAD) begin
      // loads only matter in run mode; pending edits turn them into a write-back
      if (ed_mode == MODE_RUN) begin
        if (ed_dirty) begin
          wb = 1'b1;
          ed_dirty = 1'b0;
        end else begin
          ed_second  = r.load_second;
          ed_minute  = r.load_minute;
          ed_hour    = r.load_hour;
          ed_weekday = r.load_weekday;
          ed_date    = r.load_date;
          ed_month   = r.load_month;
          ed_year    = r.load_year;
        end
      end
    end else begin
      // set falling edge steps the mode; with clear held it loads the default date
      if (prev_set && !r.btn_set) begin
        if (!r.btn_clear) begin
          ed_second  = '0;
          ed_minute  = '0;
          ed_hour    = '0;
          ed_weekday = DEF_WEEKDAY;
          ed_date    = DEF_DATE;
          ed_month   = DEF_MONTH;
          ed_year    = DEF_YEAR;
          wb = 1'b1;
        end
        ed_mode = ed_mode + 3'd1;
      end
      prev_set = r.btn_set;
      if (!r.btn_clear) begin
        ed_mode = MODE_RUN;
      end
      // up and down only seen while editing; up acts before down
      if (ed_mode != MODE_RUN) begin
        up_edge   = prev_up && !r.btn_up;
        down_edge = prev_down && !r.btn_down;
        prev_up   = r.btn_up;
        prev_down = r.btn_down;
        ed_dirty  = 1'b1;
        if (up_edge) begin
          nudge_field(1'b1);
        end
        if (down_edge) begin
          nudge_field(1'b0);
        end
      end
    end
    o.edit_mode   = ed_mode;
    o.out_hour    = ed_hour;
    o.out_minute  = ed_minute;
    o.out_second  = ed_second;
    o.out_weekday = ed_weekday;
    o.out_date    = ed_date;
    o.out_month   = ed_month;
    o.out_year    = ed_year;
    o.write_back  = wb;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // request builders
  // ---------------------------------------------------------------------------

  // button sample, load fields carry random junk that must be ignored
  function automatic void push_button(input logic s, input logic u, input logic d,
                                      input logic c);
    ccfe_in_t   r;
    logic [63:0] w;
    w = {$urandom, $urandom};
    r = w[$bits(ccfe_in_t)-1:0];
    r.op        = OP_BUTTON;
    r.btn_set   = s;
    r.btn_up    = u;
    r.btn_down  = d;
    r.btn_clear = c;
    pending_reqs.push_back(r);
  endfunction

  // chip load, button levels carry random junk that must be ignored
  function automatic void push_load(input logic [5:0] sec, input logic [5:0] min,
                                    input logic [4:0] hr, input logic [2:0] wd,
                                    input logic [4:0] dt, input logic [3:0] mo,
                                    input logic [6:0] yr);
    ccfe_in_t r;
    r.op           = OP_LOAD;
    r.btn_set      = 1'($urandom);
    r.btn_up       = 1'($urandom);
    r.btn_down     = 1'($urandom);
    r.btn_clear    = 1'($urandom);
    r.load_second  = sec;
    r.load_minute  = min;
    r.load_hour    = hr;
    r.load_weekday = wd;
    r.load_date    = dt;
    r.load_month   = mo;
    r.load_year    = yr;
    pending_reqs.push_back(r);
  endfunction

  // chip load with every field random, out-of-range values included
  function automatic void push_load_junk();
    push_load(6'($urandom), 6'($urandom), 5'($urandom), 3'($urandom), 5'($urandom),
              4'($urandom), 7'($urandom));
  endfunction

  function automatic string fmt_display(input ccfe_out_t v);
    return $sformatf("mode %0d %0d:%0d:%0d wd %0d %0d/%0d/%0d wb %0d", v.edit_mode,
                     v.out_hour, v.out_minute, v.out_second, v.out_weekday, v.out_date,
                     v.out_month, v.out_year, v.write_back);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued requests, predicts each one as it is accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    logic send;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_display.push_back(apply_request(in_data));
        n_accepted++;
        if (in_data.op == OP_LOAD) begin
          n_loads++;
        end
      end
      // payload only moves once the current request is gone
      if (!in_valid || in_ready) begin
        // no idling while the receiver holds off, so the block backs up
        send = (pending_reqs.size() != 0) &&
               (no_idle || hold_rx || $urandom_range(99) >= 23);
        if (send) begin
          in_data  <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compares each result against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    ccfe_out_t want;
    string     diffs;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        modes_seen[out_data.edit_mode] = 1'b1;
        if (out_data.write_back) begin
          n_write_backs++;
        end
        if (expected_display.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with no request pending: %s", $realtime,
                     fmt_display(out_data));
          end
        end else begin
          want  = expected_display.pop_front();
          diffs = "";
          if (out_data.edit_mode !== want.edit_mode) diffs = {diffs, " edit_mode"};
          if (out_data.out_hour !== want.out_hour) diffs = {diffs, " hour"};
          if (out_data.out_minute !== want.out_minute) diffs = {diffs, " minute"};
          if (out_data.out_second !== want.out_second) diffs = {diffs, " second"};
          if (out_data.out_weekday !== want.out_weekday) diffs = {diffs, " weekday"};
          if (out_data.out_date !== want.out_date) diffs = {diffs, " date"};
          if (out_data.out_month !== want.out_month) diffs = {diffs, " month"};
          if (out_data.out_year !== want.out_year) diffs = {diffs, " year"};
          if (out_data.write_back !== want.write_back) diffs = {diffs, " write_back"};
          if (diffs != "") begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result %0d differs in%s", $realtime, n_results, diffs);
              $display("  expected %s", fmt_display(want));
              $display("  actual   %s", fmt_display(out_data));
            end
          end
        end
      end
      out_ready <= !hold_rx && (no_idle || $urandom_range(99) >= 23);
    end
  end

  // long receiver hold-off, counted in cycles, so the block fills and stalls its input
  initial begin
    wait (n_accepted >= 900);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (300) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic lv_set;
    logic lv_up;
    logic lv_down;
    int   pick;

    // out-of-range chip values stored as given, then edited from out of range
    push_load(6'h3f, 6'h3f, 5'h1f, 3'h7, 5'h1f, 4'hf, 7'h7f);
    push_button(1'b1, 1'b1, 1'b1, 1'b1);
    push_button(1'b0, 1'b1, 1'b1, 1'b1);  // hour edit
    push_button(1'b0, 1'b0, 1'b1, 1'b1);  // up from out of range goes to the bottom
    push_button(1'b0, 1'b1, 1'b0, 1'b1);  // down from the bottom goes to the top
    push_button(1'b1, 1'b1, 1'b1, 1'b1);
    push_button(1'b0, 1'b1, 1'b1, 1'b1);  // minute edit
    push_button(1'b0, 1'b0, 1'b0, 1'b1);  // up and down on the same request
    push_load(6'd1, 6'd2, 5'd3, 3'd4, 5'd5, 4'd6, 7'd7);  // ignored while editing
    push_button(1'b1, 1'b1, 1'b1, 1'b0);  // clear forces run mode
    push_load(6'd0, 6'd0, 5'd0, 3'd0, 5'd0, 4'd0, 7'd0);  // edits pending: write-back
    push_load(6'd0, 6'd0, 5'd0, 3'd0, 5'd0, 4'd0, 7'd0);  // all zeros stored
    push_button(1'b1, 1'b1, 1'b1, 1'b1);
    push_button(1'b0, 1'b1, 1'b1, 1'b0);  // set with clear: default date and write-back
    // walk every edit mode, up on odd modes but the hour and down on even ones, then wrap to run
    for (int m = 1; m <= 8; m++) begin
      push_button(1'b1, 1'b1, 1'b1, 1'b1);
      push_button(1'b0, m[0] ? 1'b0 : 1'b1, m[0] ? 1'b1 : 1'b0, 1'b1);
    end
    push_load(6'd59, 6'd59, 5'd23, 3'd7, 5'd31, 4'd12, 7'd99);

    // random part: mostly button level walks so set, up and down edges come often
    lv_set  = 1'b1;
    lv_up   = 1'b1;
    lv_down = 1'b1;
    for (int i = 0; i < 1600; i++) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        // noise: any bit pattern at all
        push_button(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
        if ($urandom_range(1) == 1) begin
          push_load_junk();
        end
      end else if (pick < 18) begin
        if ($urandom_range(9) < 6) begin
          push_load(6'($urandom_range(59)), 6'($urandom_range(59)),
                    5'($urandom_range(23)), 3'($urandom_range(7, 1)),
                    5'($urandom_range(31, 1)), 4'($urandom_range(12, 1)),
                    7'($urandom_range(99)));
        end else begin
          push_load_junk();
        end
      end else begin
        if ($urandom_range(99) < 35) lv_set = !lv_set;
        if ($urandom_range(99) < 35) lv_up = !lv_up;
        if ($urandom_range(99) < 35) lv_down = !lv_down;
        // clear is pressed rarely, otherwise the editor never gets past run mode
        push_button(lv_set, lv_up, lv_down, ($urandom_range(99) < 4) ? 1'b0 : 1'b1);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // drain: everything sent, everything back, then a final wait for stray results
    @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_display.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("ran %0d requests (%0d chip loads), %0d results, %0d write-backs",
             n_accepted, n_loads, n_results, n_write_backs);
    $display("edit modes shown: %b, receiver hold-off of 300 cycles included", modes_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1_600_000;
    $display("timeout with %0d results still expected", expected_display.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/ccfe_pkg.sv
hw/rtl/ccfe_core.sv
hw/rtl/clock_calendar_field_editor.sv
test/tb_clock_calendar_field_editor.sv
